// File: rtl/fpp_pkg.sv
// Shared types, codes and helpers of the framebuffer pixel plotter.
`default_nettype none

package fpp_pkg;

   localparam int ADDR_W   = 22;
   localparam int CNT_W    = ADDR_W + 1;
   localparam int STRIDE_W = 16;
   localparam int SCALE_W  = 5;
   localparam int ROW_W    = ADDR_W + 1;

   typedef enum logic [1:0] {
      CMD_PLOT  = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_CLIPPED = 2'd1,
      ST_BEYOND  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_VIEW_WIDTH  = 2'd0,
      REG_VIEW_HEIGHT = 2'd1,
      REG_PIXEL_SCALE = 2'd2,
      REG_CLEAR_COLOR = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      OP_REPORT = 3'd0,
      OP_READ   = 3'd1,
      OP_BLEND  = 3'd2,
      OP_WRITE  = 3'd3,
      OP_CLEAR  = 3'd4
   } op_type;

   typedef struct packed {
      op_type                op;
      status_type            status;
      logic [31:0]           color;
      logic [ADDR_W-1:0]     addr;
      logic [STRIDE_W-1:0]   stride;
      logic [SCALE_W-1:0]    scale;
      logic [CNT_W-1:0]      count;
   } desc_type;

   function automatic logic [7:0] div255(input logic [15:0] v);
      logic [16:0] t;
      t = 17'(v) + 17'(v[15:8]) + 17'd1;
      return t[15:8];
   endfunction

endpackage

`default_nettype wire

// File: rtl/fpp_if.sv
// Channel interfaces: plot requests, responses and register writes.
`default_nettype none

interface fpp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [10:0] pos_x;
   logic [10:0] pos_y;
   logic [7:0]  red_in;
   logic [7:0]  green_in;
   logic [7:0]  blue_in;
   logic [7:0]  alpha_in;
   logic [17:0] read_addr;
   modport source (output valid, cmd, pos_x, pos_y, red_in, green_in, blue_in, alpha_in,
                   read_addr, input ready);
   modport sink (input valid, cmd, pos_x, pos_y, red_in, green_in, blue_in, alpha_in,
                 read_addr, output ready);
endinterface

interface fpp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic [7:0] alpha_out;
   modport source (output valid, status, red_out, green_out, blue_out, alpha_out,
                   input ready);
   modport sink (input valid, status, red_out, green_out, blue_out, alpha_out,
                 output ready);
endinterface

interface fpp_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/fpp_front.sv
// Front end: register file, request capture, clipping and address set-up.
`default_nettype none

module fpp_front #(
   parameter int unsigned FB_WORDS  = 262144,
   parameter int unsigned MAX_SCALE = 8
) (
   input  logic              clock,
   input  logic              reset,
   fpp_req_if.sink           req,
   fpp_csr_if.sink           csr,
   output logic              push_valid,
   input  logic              push_ready,
   output fpp_pkg::desc_type push_data
);
   import fpp_pkg::*;

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_MUL1 = 4'b0010,
      F_MUL2 = 4'b0100,
      F_PUSH = 4'b1000
   } front_state_type;

   front_state_type state_ff, state_in;

   logic [10:0] vw_ff, vh_ff;
   logic [3:0]  ps_ff;
   logic [31:0] cc_ff;

   logic [1:0]  cmd_ff;
   logic [10:0] x_ff, y_ff;
   logic [31:0] color_ff;
   logic [17:0] raddr_ff;

   logic [15:0] ys_ff, xs_ff, stride_ff;
   logic [21:0] area_ff;
   logic [9:0]  ss_ff;
   logic        clip_ff;
   logic [32:0] top_ff;
   logic [31:0] cnt_ff;

   logic [SCALE_W-1:0] scale;
   logic [15:0]        ys_in, xs_in, stride_in;
   logic [21:0]        area_in;
   logic [9:0]         ss_in;
   logic [32:0]        top_in;
   logic [31:0]        cnt_in;
   desc_type           desc;

   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == F_IDLE);

   always_comb begin
      if (ps_ff == 4'd0) begin
         scale = SCALE_W'(1);
      end else if (SCALE_W'(ps_ff) > SCALE_W'(MAX_SCALE)) begin
         scale = SCALE_W'(MAX_SCALE);
      end else begin
         scale = SCALE_W'(ps_ff);
      end
   end

   assign ys_in     = 16'(y_ff) * 16'(scale);
   assign xs_in     = 16'(x_ff) * 16'(scale);
   assign stride_in = 16'(vw_ff) * 16'(scale);
   assign area_in   = 22'(vw_ff) * 22'(vh_ff);
   assign ss_in     = 10'(scale) * 10'(scale);
   assign top_in    = 33'(32'(ys_ff) * 32'(stride_ff)) + 33'(xs_ff);
   assign cnt_in    = 32'(area_ff) * 32'(ss_ff);

   always_comb begin
      desc        = '0;
      desc.op     = OP_REPORT;
      desc.status = ST_DONE;
      desc.stride = STRIDE_W'(stride_ff);
      desc.scale  = scale;
      case (cmd_ff)
         CMD_PLOT: begin
            if (clip_ff) begin
               desc.status = ST_CLIPPED;
            end else if (top_ff >= 33'(FB_WORDS)) begin
               desc.status = ST_BEYOND;
            end else begin
               desc.op    = (color_ff[31:24] == 8'hFF) ? OP_WRITE : OP_BLEND;
               desc.color = color_ff;
               desc.addr  = top_ff[ADDR_W-1:0];
            end
         end
         CMD_CLEAR: begin
            desc.op    = OP_CLEAR;
            desc.color = cc_ff;
            desc.count = (cnt_ff > 32'(FB_WORDS)) ? CNT_W'(FB_WORDS) : cnt_ff[CNT_W-1:0];
         end
         CMD_READ: begin
            if (32'(raddr_ff) >= 32'(FB_WORDS)) begin
               desc.status = ST_BEYOND;
            end else begin
               desc.op   = OP_READ;
               desc.addr = ADDR_W'(raddr_ff);
            end
         end
         default: begin
            desc.op = OP_REPORT;
         end
      endcase
   end

   assign push_valid = (state_ff == F_PUSH);
   assign push_data  = desc;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: if (req.valid) state_in = F_MUL1;
         F_MUL1: state_in = F_MUL2;
         F_MUL2: state_in = F_PUSH;
         F_PUSH: if (push_ready) state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         vw_ff    <= 11'd320;
         vh_ff    <= 11'd200;
         ps_ff    <= 4'd1;
         cc_ff    <= 32'hFF00_0000;
      end else begin
         state_ff <= state_in;
         if (csr.valid) begin
            unique case (reg_index_type'(csr.index))
               REG_VIEW_WIDTH:  vw_ff <= csr.data[10:0];
               REG_VIEW_HEIGHT: vh_ff <= csr.data[10:0];
               REG_PIXEL_SCALE: ps_ff <= csr.data[3:0];
               REG_CLEAR_COLOR: cc_ff <= csr.data;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && req.valid) begin
         cmd_ff   <= req.cmd;
         x_ff     <= req.pos_x;
         y_ff     <= req.pos_y;
         color_ff <= {req.alpha_in, req.red_in, req.green_in, req.blue_in};
         raddr_ff <= req.read_addr;
      end
      if (state_ff == F_MUL1) begin
         ys_ff     <= ys_in;
         xs_ff     <= xs_in;
         stride_ff <= stride_in;
         area_ff   <= area_in;
         ss_ff     <= ss_in;
         clip_ff   <= (x_ff >= vw_ff) || (y_ff >= vh_ff);
      end
      if (state_ff == F_MUL2) begin
         top_ff <= top_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/fpp_queue.sv
// Two-entry queue of decoded commands between front and back end.
`default_nettype none

module fpp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  fpp_pkg::desc_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output fpp_pkg::desc_type pop_data
);
   import fpp_pkg::*;

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

// File: rtl/fpp_back.sv
// Back end: frame memory, blend datapath, block and clear sweeps, response register.
`default_nettype none

module fpp_back #(
   parameter int unsigned FB_WORDS = 262144
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  fpp_pkg::desc_type pop_data,
   fpp_rsp_if.source         rsp
);
   import fpp_pkg::*;

   localparam int AW = $clog2(FB_WORDS);

   typedef enum logic [6:0] {
      B_IDLE  = 7'b0000001,
      B_FETCH = 7'b0000010,
      B_MUL   = 7'b0000100,
      B_SUM   = 7'b0001000,
      B_PAINT = 7'b0010000,
      B_CLEAR = 7'b0100000,
      B_LOAD  = 7'b1000000
   } back_state_type;

   back_state_type state_ff, state_in;
   desc_type       desc_ff;

   logic [31:0] frame_mem [FB_WORDS];
   logic [31:0] rd_data_ff;
   logic [31:0] word_ff, word_in;

   logic [2:0][15:0] po_ff, pb_ff, po_in, pb_in;

   logic [SCALE_W-1:0] xo_ff, yo_ff;
   logic [ROW_W-1:0]   row_ff, paint_addr;
   logic [CNT_W-1:0]   clr_ff;

   logic        we;
   logic [AW-1:0] waddr;
   logic [31:0] wdata;
   logic        row_end, block_end, clear_end, load;

   logic        out_valid_ff;
   logic [1:0]  out_status_ff;
   logic [31:0] out_word_ff;

   assign pop_ready  = (state_ff == B_IDLE);
   assign paint_addr = row_ff + ROW_W'(xo_ff);
   assign row_end    = (xo_ff == desc_ff.scale - SCALE_W'(1));
   assign block_end  = row_end && (yo_ff == desc_ff.scale - SCALE_W'(1));
   assign clear_end  = (clr_ff + CNT_W'(1) == desc_ff.count);
   assign load       = (state_ff == B_LOAD) && (!out_valid_ff || rsp.ready);

   always_comb begin
      logic [7:0] a;
      logic [8:0] sum;
      a       = desc_ff.color[31:24];
      word_in = {a, 24'h0};
      for (int i = 0; i < 3; i++) begin
         po_in[i] = 16'(a) * 16'(desc_ff.color[8*i +: 8]);
         pb_in[i] = 16'(8'd255 - a) * 16'(rd_data_ff[8*i +: 8]);
         sum      = 9'(div255(po_ff[i])) + 9'(div255(pb_ff[i]));
         word_in[8*i +: 8] = sum[8] ? 8'hFF : sum[7:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               unique case (pop_data.op)
                  OP_READ, OP_BLEND: state_in = B_FETCH;
                  OP_WRITE:          state_in = B_PAINT;
                  OP_CLEAR:          state_in = (pop_data.count == '0) ? B_LOAD : B_CLEAR;
                  default:           state_in = B_LOAD;
               endcase
            end
         end
         B_FETCH: state_in = (desc_ff.op == OP_READ) ? B_LOAD : B_MUL;
         B_MUL:   state_in = (desc_ff.color[31:24] == 8'h00) ? B_PAINT : B_SUM;
         B_SUM:   state_in = B_PAINT;
         B_PAINT: if (block_end) state_in = B_LOAD;
         B_CLEAR: if (clear_end) state_in = B_LOAD;
         B_LOAD:  if (load) state_in = B_IDLE;
      endcase
   end

   always_comb begin
      we    = 1'b0;
      waddr = paint_addr[AW-1:0];
      wdata = word_ff;
      if (state_ff == B_PAINT) begin
         we = (paint_addr < ROW_W'(FB_WORDS));
      end else if (state_ff == B_CLEAR) begin
         we    = 1'b1;
         waddr = clr_ff[AW-1:0];
         wdata = desc_ff.color;
      end
   end

   always_ff @(posedge clock) begin
      if (we) frame_mem[waddr] <= wdata;
      rd_data_ff <= frame_mem[desc_ff.addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      priority case (1'b1)
         (state_ff == B_IDLE): begin
            desc_ff <= pop_data;
            word_ff <= pop_data.color;
            row_ff  <= ROW_W'(pop_data.addr);
            xo_ff   <= '0;
            yo_ff   <= '0;
            clr_ff  <= '0;
         end
         (state_ff == B_MUL): begin
            po_ff <= po_in;
            pb_ff <= pb_in;
            if (desc_ff.color[31:24] == 8'h00) word_ff <= rd_data_ff;
         end
         (state_ff == B_SUM): begin
            word_ff <= word_in;
         end
         (state_ff == B_PAINT): begin
            if (row_end) begin
               xo_ff  <= '0;
               yo_ff  <= yo_ff + SCALE_W'(1);
               row_ff <= row_ff + ROW_W'(desc_ff.stride);
            end else begin
               xo_ff <= xo_ff + SCALE_W'(1);
            end
         end
         (state_ff == B_CLEAR): begin
            clr_ff <= clr_ff + CNT_W'(1);
         end
         default: begin
         end
      endcase
      if (load) begin
         out_status_ff <= desc_ff.status;
         out_word_ff   <= (desc_ff.op == OP_READ) ? rd_data_ff : word_ff;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.status    = out_status_ff;
   assign rsp.alpha_out = out_word_ff[31:24];
   assign rsp.red_out   = out_word_ff[23:16];
   assign rsp.green_out = out_word_ff[15:8];
   assign rsp.blue_out  = out_word_ff[7:0];

   a_paint_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_PAINT) |-> (xo_ff < desc_ff.scale && yo_ff < desc_ff.scale))
      else $error("block offset beyond scale");

   a_clear_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_CLEAR) |-> (clr_ff < desc_ff.count))
      else $error("clear index beyond length");

   a_write_range: assert property (@(posedge clock) disable iff (reset)
      we |-> (32'(waddr) < 32'(FB_WORDS)))
      else $error("frame write beyond capacity");

   a_load_src: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == B_LOAD))
      else $error("response raised outside load");

endmodule

`default_nettype wire

// File: rtl/framebuffer_alpha_pixel_plotter.sv
// Top level of the framebuffer alpha pixel plotter.
//
// Usage: requests arrive on req (plot, clear or read); every request
// gives exactly one beat on rsp. Registers are written on csr, which is
// always ready; the user must write them only while no request is in
// flight, as the block does not enforce this.
// The front end captures each request, passes two multiply stages and
// hands it to a two-entry queue; it takes a new request only after the
// last one has gone into the queue. The back end owns the frame memory
// (one write and one read port): an opaque plot writes its scale*scale
// block, a translucent plot first reads and passes two blend stages, a
// clear writes its word count and a clipped or out-of-range request goes
// straight to the response. The memory write port sets the rate.
// Reset clears the control state and restores the register defaults;
// the frame memory keeps its contents and is undefined until written.
// A stalled rsp holds the response register; the back end stops at the
// next response, the queue fills and req ready drops.
`default_nettype none

module framebuffer_alpha_pixel_plotter #(
   parameter int unsigned FB_WORDS  = 262144,
   parameter int unsigned MAX_SCALE = 8
) (
   input  logic       clock,
   input  logic       reset,
   fpp_req_if.sink    req,
   fpp_rsp_if.source  rsp,
   fpp_csr_if.sink    csr
);
   import fpp_pkg::*;

   logic     push_valid, push_ready, pop_valid, pop_ready;
   desc_type push_data, pop_data;

   fpp_front #(
      .FB_WORDS  (FB_WORDS),
      .MAX_SCALE (MAX_SCALE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr        (csr),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   fpp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   fpp_back #(
      .FB_WORDS (FB_WORDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

// File: sim/tb_framebuffer_alpha_pixel_plotter.sv
`timescale 1ns / 100ps
// Testbench for the pixel plotter: a directed table, then random phases checked against a frame model.

module tb_framebuffer_alpha_pixel_plotter;
   import fpp_pkg::*;

   localparam int FB_WORDS       = 262144;
   localparam int MAX_SCALE      = 8;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int RAND_PHASES    = 12;
   localparam int PHASE_BEATS    = 163;
   localparam int CLEAR_BUDGET   = 4096;
   localparam int HOLD_AT_RSP    = 300;
   localparam int HOLD_CYCLES    = 250;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 1200000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      logic [1:0]  cmd;
      logic [10:0] pos_x;
      logic [10:0] pos_y;
      logic [31:0] argb;
      logic [17:0] read_addr;
   } plot_beat_type;

   typedef struct {
      status_type  status;
      logic [31:0] argb;
   } plot_reply_type;

   typedef struct {
      bit             reg_write;
      reg_index_type  reg_idx;
      logic [31:0]    reg_data;
      plot_beat_type  beat;
      bit             typed;
      plot_reply_type want;
   } stim_row_type;

   typedef struct {
      reg_index_type idx;
      logic [31:0]   data;
   } reg_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fpp_req_if req_ch ();
   fpp_rsp_if rsp_ch ();
   fpp_csr_if csr_ch ();

   framebuffer_alpha_pixel_plotter u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always #2 clock = ~clock;

   logic [31:0]    frame_shadow [FB_WORDS];
   logic [10:0]    view_w     = 11'd320;
   logic [10:0]    view_h     = 11'd200;
   logic [3:0]     view_s     = 4'd1;
   logic [31:0]    view_clear = 32'hFF000000;
   plot_reply_type pending_replies [$];
   stim_row_type   directed_rows [$];
   reg_write_type  reg_writes [$];
   int unsigned    recent_tops [$];
   int             mismatches = 0;
   int             rsp_beats = 0;
   int             idle_cycles = 0;
   int             burst_left = 0;
   int             hold_left = 0;
   bit             hold_done = 1'b0;
   logic [7:0]     stall_pattern = 8'hFF;
   int             stall_pos = 0;

   function automatic int unsigned scale_used();
      if (view_s == 4'd0) return 1;
      if (view_s > MAX_SCALE) return MAX_SCALE;
      return 32'(view_s);
   endfunction

   function automatic logic [7:0] mix_channel(int unsigned a, int unsigned o, int unsigned b);
      int unsigned v;
      v = (a * o) / 255 + ((255 - a) * b) / 255;
      return (v > 255) ? 8'hFF : v[7:0];
   endfunction

   function automatic plot_reply_type apply_beat(plot_beat_type b);
      plot_reply_type  r;
      longint unsigned s, w, top, addr, n, yo, xo;
      logic [31:0]     color, base;
      r.status = ST_DONE;
      r.argb   = '0;
      s = scale_used();
      w = view_w * s;
      case (b.cmd)
         CMD_PLOT: begin
            if (b.pos_x >= view_w || b.pos_y >= view_h) begin
               r.status = ST_CLIPPED;
            end else begin
               top = b.pos_y * s * w + b.pos_x * s;
               if (top >= FB_WORDS) begin
                  r.status = ST_BEYOND;
               end else begin
                  color = b.argb;
                  base  = frame_shadow[top];
                  if (color[31:24] == 8'd0) begin
                     color = base;
                  end else if (color[31:24] != 8'hFF) begin
                     color = {color[31:24],
                              mix_channel(32'(color[31:24]), 32'(color[23:16]),
                                          32'(base[23:16])),
                              mix_channel(32'(color[31:24]), 32'(color[15:8]),
                                          32'(base[15:8])),
                              mix_channel(32'(color[31:24]), 32'(color[7:0]),
                                          32'(base[7:0]))};
                  end
                  for (yo = 0; yo < s; yo++) begin
                     for (xo = 0; xo < s; xo++) begin
                        addr = top + yo * w + xo;
                        if (addr < FB_WORDS) frame_shadow[addr] = color;
                     end
                  end
                  r.argb = color;
                  recent_tops.push_back(32'(top));
                  if (recent_tops.size() > 16) void'(recent_tops.pop_front());
               end
            end
         end
         CMD_CLEAR: begin
            n = view_w * view_h * s * s;
            if (n > FB_WORDS) n = FB_WORDS;
            for (addr = 0; addr < n; addr++) frame_shadow[addr] = view_clear;
            r.argb = view_clear;
         end
         CMD_READ: begin
            if (b.read_addr >= FB_WORDS) r.status = ST_BEYOND;
            else r.argb = frame_shadow[b.read_addr];
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic stim_row_type blank_row();
      stim_row_type row;
      row.reg_write      = 1'b0;
      row.reg_idx        = REG_VIEW_WIDTH;
      row.reg_data       = '0;
      row.beat.cmd       = CMD_PLOT;
      row.beat.pos_x     = '0;
      row.beat.pos_y     = '0;
      row.beat.argb      = '0;
      row.beat.read_addr = '0;
      row.typed          = 1'b0;
      row.want.status    = ST_DONE;
      row.want.argb      = '0;
      return row;
   endfunction

   function automatic void add_reg(reg_index_type idx, logic [31:0] data);
      stim_row_type row;
      row = blank_row();
      row.reg_write = 1'b1;
      row.reg_idx   = idx;
      row.reg_data  = data;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_beat(logic [1:0] cmd, int x, int y, logic [31:0] argb, int addr,
                                    bit typed, status_type st, logic [31:0] word);
      stim_row_type row;
      row = blank_row();
      row.beat.cmd       = cmd;
      row.beat.pos_x     = x[10:0];
      row.beat.pos_y     = y[10:0];
      row.beat.argb      = argb;
      row.beat.read_addr = addr[17:0];
      row.typed          = typed;
      row.want.status    = st;
      row.want.argb      = word;
      directed_rows.push_back(row);
   endfunction

   task automatic send_beat(input plot_beat_type b, input bit typed, input plot_reply_type want,
                            input bit last);
      plot_reply_type got;
      int             gap;
      req_ch.valid     <= 1'b1;
      req_ch.cmd       <= b.cmd;
      req_ch.pos_x     <= b.pos_x;
      req_ch.pos_y     <= b.pos_y;
      req_ch.alpha_in  <= b.argb[31:24];
      req_ch.red_in    <= b.argb[23:16];
      req_ch.green_in  <= b.argb[15:8];
      req_ch.blue_in   <= b.argb[7:0];
      req_ch.read_addr <= b.read_addr;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      got = apply_beat(b);
      if (typed) pending_replies.push_back(want);
      else pending_replies.push_back(got);
      if (last) begin
         req_ch.valid <= 1'b0;
      end else if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                  : $urandom_range(0, 12);
         gap = $urandom_range(1, 8);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_registers();
      while (pending_replies.size() != 0) @(posedge clock);
      foreach (reg_writes[i]) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= reg_writes[i].idx;
         csr_ch.data  <= reg_writes[i].data;
         do @(posedge clock); while (csr_ch.ready !== 1'b1);
         case (reg_writes[i].idx)
            REG_VIEW_WIDTH:  view_w     = reg_writes[i].data[10:0];
            REG_VIEW_HEIGHT: view_h     = reg_writes[i].data[10:0];
            REG_PIXEL_SCALE: view_s     = reg_writes[i].data[3:0];
            REG_CLEAR_COLOR: view_clear = reg_writes[i].data;
            default: ;
         endcase
      end
      csr_ch.valid <= 1'b0;
      reg_writes.delete();
   endtask

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (!hold_done && rsp_beats >= HOLD_AT_RSP) begin
         hold_done    <= 1'b1;
         hold_left    <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= stall_pattern[stall_pos];
         if (stall_pos == 7) begin
            stall_pos <= 0;
            if ($urandom_range(0, 3) == 0)
               stall_pattern <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
         end else begin
            stall_pos <= stall_pos + 1;
         end
      end
   end

   always @(posedge clock) begin
      plot_reply_type want;
      logic [31:0]    got_argb;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         rsp_beats <= rsp_beats + 1;
         got_argb = {rsp_ch.alpha_out, rsp_ch.red_out, rsp_ch.green_out, rsp_ch.blue_out};
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected beat: status %0d argb %08h", rsp_ch.status, got_argb);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_ch.status !== want.status || rsp_ch.alpha_out !== want.argb[31:24] ||
                rsp_ch.red_out !== want.argb[23:16] || rsp_ch.green_out !== want.argb[15:8] ||
                rsp_ch.blue_out !== want.argb[7:0]) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("mismatch: status exp %0d got %0d, argb exp %08h got %08h",
                           want.status, rsp_ch.status, want.argb, got_argb);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
          (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      plot_beat_type   nb;
      plot_reply_type  none;
      int unsigned     sel, pick, s;
      int              w, h, sc;
      longint unsigned addr_pick, span;
      none.status      = ST_DONE;
      none.argb        = '0;
      req_ch.valid     = 1'b0;
      req_ch.cmd       = CMD_PLOT;
      req_ch.pos_x     = '0;
      req_ch.pos_y     = '0;
      req_ch.red_in    = '0;
      req_ch.green_in  = '0;
      req_ch.blue_in   = '0;
      req_ch.alpha_in  = '0;
      req_ch.read_addr = '0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = REG_VIEW_WIDTH;
      csr_ch.data      = '0;

      add_beat(CMD_CLEAR, 0, 0, 32'h0, 0, 1, ST_DONE, 32'hFF000000);
      add_beat(CMD_PLOT, 0, 0, 32'hFFFF0080, 0, 1, ST_DONE, 32'hFFFF0080);
      add_beat(CMD_PLOT, 319, 199, 32'hFF00FF7F, 0, 1, ST_DONE, 32'hFF00FF7F);
      add_beat(CMD_PLOT, 320, 0, 32'hFFFF0080, 0, 1, ST_CLIPPED, 32'h0);
      add_beat(CMD_PLOT, 0, 200, 32'hFFFF0080, 0, 1, ST_CLIPPED, 32'h0);
      add_beat(CMD_PLOT, 2047, 2047, 32'hFF00FF7F, 0, 1, ST_CLIPPED, 32'h0);
      add_beat(CMD_READ, 0, 0, 32'h0, 0, 1, ST_DONE, 32'hFFFF0080);
      add_beat(CMD_READ, 0, 0, 32'h0, 63999, 1, ST_DONE, 32'hFF00FF7F);
      add_beat(CMD_PLOT, 0, 0, 32'h00123456, 0, 1, ST_DONE, 32'hFFFF0080);
      add_beat(CMD_PLOT, 0, 0, 32'h80FF40C0, 0, 0, ST_DONE, 32'h0);
      add_beat(CMD_PLOT, 1, 0, 32'hFE0000FF, 0, 0, ST_DONE, 32'h0);
      add_beat(CMD_PLOT, 2, 0, 32'h01FFFFFF, 0, 0, ST_DONE, 32'h0);
      add_beat(CMD_UNUSED, 5, 5, 32'hFFFFFFFF, 262143, 1, ST_DONE, 32'h0);
      add_reg(REG_VIEW_WIDTH, 32'd1024);
      add_reg(REG_VIEW_HEIGHT, 32'd1024);
      add_reg(REG_PIXEL_SCALE, 32'd8);
      add_reg(REG_CLEAR_COLOR, 32'h5AC33CA5);
      add_beat(CMD_CLEAR, 0, 0, 32'h0, 0, 1, ST_DONE, 32'h5AC33CA5);
      add_beat(CMD_READ, 0, 0, 32'h0, 262143, 1, ST_DONE, 32'h5AC33CA5);
      add_beat(CMD_PLOT, 1023, 1023, 32'hFF102030, 0, 1, ST_BEYOND, 32'h0);
      add_beat(CMD_PLOT, 3, 3, 32'hC8102030, 0, 0, ST_DONE, 32'h0);
      add_beat(CMD_READ, 0, 0, 32'h0, 204824, 0, ST_DONE, 32'h0);
      add_reg(REG_VIEW_WIDTH, 32'd1000);
      add_reg(REG_PIXEL_SCALE, 32'd15);
      add_beat(CMD_PLOT, 700, 4, 32'hFFAA55AA, 0, 0, ST_DONE, 32'h0);
      add_beat(CMD_PLOT, 767, 4, 32'h5A0F0F0F, 0, 0, ST_DONE, 32'h0);
      add_beat(CMD_READ, 0, 0, 32'h0, 262143, 0, ST_DONE, 32'h0);
      add_reg(REG_VIEW_WIDTH, 32'd0);
      add_beat(CMD_PLOT, 0, 0, 32'hFFFFFFFF, 0, 1, ST_CLIPPED, 32'h0);
      add_beat(CMD_CLEAR, 0, 0, 32'h0, 0, 1, ST_DONE, 32'h5AC33CA5);
      add_reg(REG_VIEW_WIDTH, 32'd2047);
      add_reg(REG_VIEW_HEIGHT, 32'd2047);
      add_reg(REG_PIXEL_SCALE, 32'd0);
      add_reg(REG_CLEAR_COLOR, 32'hFFFFFFFF);
      add_beat(CMD_PLOT, 2046, 2046, 32'hFF000000, 0, 1, ST_BEYOND, 32'h0);
      add_beat(CMD_PLOT, 0, 0, 32'hFFFFFFFF, 0, 1, ST_DONE, 32'hFFFFFFFF);
      add_beat(CMD_PLOT, 5, 0, 32'h07808080, 0, 0, ST_DONE, 32'h0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].reg_write) begin
            reg_writes.push_back('{idx: directed_rows[i].reg_idx, data: directed_rows[i].reg_data});
            if (i + 1 == directed_rows.size() || !directed_rows[i + 1].reg_write)
               write_registers();
         end else begin
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want,
                      i + 1 == directed_rows.size() || directed_rows[i + 1].reg_write);
         end
      end

      for (int p = 0; p < RAND_PHASES; p++) begin
         sel = $urandom_range(0, 9);
         if (sel == 0) begin
            w = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 40);
            h = (w == 0) ? $urandom_range(0, 40) : 0;
            sc = $urandom_range(0, 15);
         end else if (sel <= 2) begin
            w = $urandom_range(1, 2047);
            h = $urandom_range(1, 2047);
            sc = $urandom_range(0, 15);
         end else begin
            w = $urandom_range(1, 48);
            h = $urandom_range(1, 48);
            sc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
         end
         reg_writes.push_back('{idx: REG_VIEW_WIDTH, data: ($urandom & ~32'h7FF) | 32'(w)});
         reg_writes.push_back('{idx: REG_VIEW_HEIGHT, data: ($urandom & ~32'h7FF) | 32'(h)});
         reg_writes.push_back('{idx: REG_PIXEL_SCALE, data: ($urandom & ~32'hF) | 32'(sc)});
         reg_writes.push_back('{idx: REG_CLEAR_COLOR, data: $urandom});
         write_registers();

         for (int k = 0; k < PHASE_BEATS; k++) begin
            nb.cmd       = CMD_PLOT;
            nb.pos_x     = 11'($urandom_range(0, 2047));
            nb.pos_y     = 11'($urandom_range(0, 2047));
            nb.argb      = $urandom;
            nb.read_addr = 18'($urandom_range(0, 262143));
            pick = $urandom_range(0, 9);
            if (pick <= 2) nb.argb[31:24] = 8'hFF;
            else if (pick == 3) nb.argb[31:24] = 8'h00;
            else if (pick == 4) nb.argb[31:24] = ($urandom_range(0, 1) == 0) ? 8'h01 : 8'hFE;
            s = scale_used();
            span = view_w * view_h * s * s;
            if (span > FB_WORDS) span = FB_WORDS;
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
               if ($urandom_range(0, 4) != 0 && view_w != 0 && view_h != 0) begin
                  nb.pos_x = 11'($urandom_range(0, view_w - 1));
                  nb.pos_y = 11'($urandom_range(0, view_h - 1));
               end
            end else if (sel < 95) begin
               nb.cmd = CMD_READ;
               pick = $urandom_range(0, 9);
               if (pick < 6 && recent_tops.size() > 0) begin
                  addr_pick = recent_tops[$urandom_range(0, recent_tops.size() - 1)] +
                              $urandom_range(0, s - 1) * view_w * s + $urandom_range(0, s - 1);
                  if (addr_pick < FB_WORDS) nb.read_addr = addr_pick[17:0];
               end else if (pick < 9 && span != 0) begin
                  nb.read_addr = 18'($urandom_range(0, int'(span) - 1));
               end
            end else if (sel < 97) begin
               nb.cmd = (span <= CLEAR_BUDGET) ? CMD_CLEAR : CMD_READ;
            end else begin
               nb.cmd = CMD_UNUSED;
            end
            send_beat(nb, 1'b0, none, k == PHASE_BEATS - 1);
         end
      end

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_replies.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
